/* rtl/cpu16_register_file_alu_macros.svh */
// Assertion macros shared by the register-file ALU block.
`ifndef CPU16_REGISTER_FILE_ALU_MACROS_SVH
`define CPU16_REGISTER_FILE_ALU_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CRF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define CRF_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/crf_pkg.sv */
// Types and constants for the register-file ALU block.
package crf_pkg;

   localparam int NUM_REGS  = 12;
   localparam int BYTE_REGS = 4;
   localparam int REG_IDX_W = $clog2(NUM_REGS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QCNT_W-1:0] QUEUE_FULL_CNT = QCNT_W'(QUEUE_DEPTH);

   localparam logic [15:0] HIGH_MASK = 16'b1111111100000000;
   localparam logic [15:0] LOW_MASK  = 16'b0000000011111111;
   localparam logic [7:0]  BYTE_MASK = 8'b11111111;

   localparam logic [2:0] KIND_MOV_IMM = 3'd0;
   localparam logic [2:0] KIND_MOV_REG = 3'd1;
   localparam logic [2:0] KIND_SUB_REG = 3'd2;
   localparam logic [2:0] KIND_CMP_REG = 3'd3;
   localparam logic [2:0] KIND_ADD_IMM = 3'd4;
   localparam logic [2:0] KIND_SUB_IMM = 3'd5;

   localparam logic [1:0] PART_CODE_WORD = 2'd0;
   localparam logic [1:0] PART_CODE_LO   = 2'd1;
   localparam logic [1:0] PART_CODE_HI   = 2'd2;

   typedef enum logic [1:0] {
      PART_WORD = 2'd0,
      PART_LO   = 2'd1,
      PART_HI   = 2'd2
   } crf_part_type;

   typedef enum logic [2:0] {
      OP_NOP = 3'd0,
      OP_MOV = 3'd1,
      OP_ADD = 3'd2,
      OP_SUB = 3'd3,
      OP_CMP = 3'd4
   } crf_op_type;

   typedef struct packed {
      crf_op_type            op;
      logic                  src_is_reg;
      logic                  zero_dest;
      logic [REG_IDX_W-1:0]  dest_idx;
      crf_part_type          dest_part;
      logic [REG_IDX_W-1:0]  src_idx;
      crf_part_type          src_part;
      logic [15:0]           imm;
   } crf_uop_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } crf_qstat_type;

endpackage

/* rtl/crf_if.sv */
// Request and response channel interfaces for the register-file ALU block.
interface crf_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [3:0]  dest_reg;
   logic [1:0]  dest_part;
   logic [3:0]  src_reg;
   logic [1:0]  src_part;
   logic [15:0] immediate;

   modport source (output valid, kind, dest_reg, dest_part, src_reg, src_part, immediate,
                   input ready);
   modport sink   (input valid, kind, dest_reg, dest_part, src_reg, src_part, immediate,
                   output ready);
endinterface

interface crf_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] dest_value;
   logic        sign_out;
   logic        zero_out;

   modport source (output valid, dest_value, sign_out, zero_out, input ready);
   modport sink   (input valid, dest_value, sign_out, zero_out, output ready);
endinterface

/* rtl/crf_front.sv */
// Front end: accepts request beats and decodes them into micro-ops.
module crf_front (
   crf_req_if.sink                req_bus,
   input  crf_pkg::crf_qstat_type q_stat,
   output logic                   push,
   output crf_pkg::crf_uop_type   push_uop
);

   logic dest_ok;
   logic src_ok;
   logic dest_bytes;
   logic src_bytes;

   assign req_bus.ready = !q_stat.full;
   assign push          = req_bus.valid && !q_stat.full;

   assign dest_ok    = req_bus.dest_reg < 4'(crf_pkg::NUM_REGS);
   assign src_ok     = req_bus.src_reg < 4'(crf_pkg::NUM_REGS);
   assign dest_bytes = req_bus.dest_reg < 4'(crf_pkg::BYTE_REGS);
   assign src_bytes  = req_bus.src_reg < 4'(crf_pkg::BYTE_REGS);

   always_comb begin
      push_uop            = '0;
      push_uop.op         = crf_pkg::OP_NOP;
      push_uop.imm        = req_bus.immediate;
      push_uop.dest_part  = crf_pkg::PART_WORD;
      push_uop.src_part   = crf_pkg::PART_WORD;

      case (req_bus.kind)
         crf_pkg::KIND_MOV_IMM: begin
            push_uop.op = crf_pkg::OP_MOV;
         end
         crf_pkg::KIND_MOV_REG: begin
            push_uop.op         = crf_pkg::OP_MOV;
            push_uop.src_is_reg = 1'b1;
         end
         crf_pkg::KIND_SUB_REG: begin
            push_uop.op         = crf_pkg::OP_SUB;
            push_uop.src_is_reg = 1'b1;
         end
         crf_pkg::KIND_CMP_REG: begin
            push_uop.op         = crf_pkg::OP_CMP;
            push_uop.src_is_reg = 1'b1;
         end
         crf_pkg::KIND_ADD_IMM: begin
            push_uop.op = crf_pkg::OP_ADD;
         end
         crf_pkg::KIND_SUB_IMM: begin
            push_uop.op = crf_pkg::OP_SUB;
         end
         default: begin
            push_uop.op = crf_pkg::OP_NOP;
         end
      endcase

      if (dest_bytes) begin
         case (req_bus.dest_part)
            crf_pkg::PART_CODE_LO: push_uop.dest_part = crf_pkg::PART_LO;
            crf_pkg::PART_CODE_HI: push_uop.dest_part = crf_pkg::PART_HI;
            default:               push_uop.dest_part = crf_pkg::PART_WORD;
         endcase
      end
      if (src_bytes) begin
         case (req_bus.src_part)
            crf_pkg::PART_CODE_LO: push_uop.src_part = crf_pkg::PART_LO;
            crf_pkg::PART_CODE_HI: push_uop.src_part = crf_pkg::PART_HI;
            default:               push_uop.src_part = crf_pkg::PART_WORD;
         endcase
      end

      if (dest_ok) begin
         push_uop.dest_idx = req_bus.dest_reg;
      end
      if (push_uop.src_is_reg && src_ok) begin
         push_uop.src_idx = req_bus.src_reg;
      end

      // out-of-range register: no effect, zero value
      if (!dest_ok || (push_uop.src_is_reg && !src_ok)) begin
         push_uop.op        = crf_pkg::OP_NOP;
         push_uop.zero_dest = 1'b1;
      end
   end

endmodule

/* rtl/crf_queue.sv */
// Small FIFO of decoded micro-ops between front and back end.
module crf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  crf_pkg::crf_uop_type   push_uop,
   input  logic                   pop,
   output crf_pkg::crf_uop_type   head_uop,
   output crf_pkg::crf_qstat_type q_stat
);

   crf_pkg::crf_uop_type              entry_ff [crf_pkg::QUEUE_DEPTH];
   logic [crf_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [crf_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [crf_pkg::QCNT_W-1:0]        count_ff, count_in;

   localparam logic [crf_pkg::QPTR_W-1:0] LastPtr = crf_pkg::QPTR_W'(crf_pkg::QUEUE_DEPTH - 1);

   assign head_uop     = entry_ff[rd_ptr_ff];
   assign q_stat.full  = count_ff == crf_pkg::QUEUE_FULL_CNT;
   assign q_stat.empty = count_ff == '0;
   assign q_stat.count = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_uop;
      end
   end

endmodule

/* rtl/crf_back.sv */
// Back end: register file read with bypass, ALU, flags and response register.
module crf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  crf_pkg::crf_uop_type   head_uop,
   input  crf_pkg::crf_qstat_type q_stat,
   output logic                   pop,
   crf_rsp_if.source              rsp_bus
);

   localparam int IdxW = crf_pkg::REG_IDX_W;

   logic [15:0]                  regfile_ff [crf_pkg::NUM_REGS];
   logic [crf_pkg::NUM_REGS-1:0] rf_valid_ff;

   logic                 ex_valid_ff;
   crf_pkg::crf_uop_type ex_uop_ff;
   logic [15:0]          rd_dest_ff;
   logic [15:0]          rd_src_ff;

   logic                 sign_ff, sign_in;
   logic                 zero_ff, zero_in;

   logic                 rsp_valid_ff;
   logic [15:0]          rsp_value_ff, rsp_value_in;
   logic                 rsp_sign_ff;
   logic                 rsp_zero_ff;

   logic                 advance;
   logic                 wr_en;
   logic [IdxW-1:0]      wr_idx;
   logic [15:0]          regfile_in;
   logic                 byte_op;
   logic                 set_flags;
   logic                 writes;
   logic [15:0]          src_val;
   logic [15:0]          operand;
   logic [15:0]          dest_val;
   logic [15:0]          alu_res;
   logic [15:0]          wr_val;

   assign advance = ex_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign pop     = !q_stat.empty && (!ex_valid_ff || advance);

   assign byte_op   = ex_uop_ff.dest_part != crf_pkg::PART_WORD;
   assign set_flags = (ex_uop_ff.op == crf_pkg::OP_ADD) || (ex_uop_ff.op == crf_pkg::OP_SUB)
                      || (ex_uop_ff.op == crf_pkg::OP_CMP);
   assign writes    = (ex_uop_ff.op == crf_pkg::OP_ADD) || (ex_uop_ff.op == crf_pkg::OP_SUB)
                      || (ex_uop_ff.op == crf_pkg::OP_MOV);

   always_comb begin
      case (ex_uop_ff.src_part)
         crf_pkg::PART_LO: src_val = {8'd0, rd_src_ff[7:0]};
         crf_pkg::PART_HI: src_val = {8'd0, rd_src_ff[15:8]};
         default:          src_val = rd_src_ff;
      endcase
      if (!ex_uop_ff.src_is_reg) begin
         src_val = ex_uop_ff.imm;
      end
      operand = byte_op ? (src_val & crf_pkg::LOW_MASK) : src_val;

      case (ex_uop_ff.dest_part)
         crf_pkg::PART_LO: dest_val = {8'd0, rd_dest_ff[7:0]};
         crf_pkg::PART_HI: dest_val = {8'd0, rd_dest_ff[15:8]};
         default:          dest_val = rd_dest_ff;
      endcase

      if (ex_uop_ff.op == crf_pkg::OP_ADD) begin
         alu_res = dest_val + operand;
      end else begin
         alu_res = dest_val - operand;
      end

      wr_val = (ex_uop_ff.op == crf_pkg::OP_MOV) ? operand : alu_res;
      case (ex_uop_ff.dest_part)
         crf_pkg::PART_LO: regfile_in = (rd_dest_ff & crf_pkg::HIGH_MASK)
                                        | {8'd0, wr_val[7:0] & crf_pkg::BYTE_MASK};
         crf_pkg::PART_HI: regfile_in = (rd_dest_ff & crf_pkg::LOW_MASK)
                                        | {wr_val[7:0] & crf_pkg::BYTE_MASK, 8'd0};
         default:          regfile_in = wr_val;
      endcase

      sign_in = sign_ff;
      zero_in = zero_ff;
      if (set_flags) begin
         sign_in = byte_op ? alu_res[7] : alu_res[15];
         zero_in = byte_op ? (alu_res[7:0] == 8'd0) : (alu_res == 16'd0);
      end

      if (ex_uop_ff.zero_dest) begin
         rsp_value_in = '0;
      end else if (writes) begin
         rsp_value_in = regfile_in;
      end else begin
         rsp_value_in = rd_dest_ff;
      end
   end

   assign wr_en  = advance && writes;
   assign wr_idx = ex_uop_ff.dest_idx;

   // register file; an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (wr_en) begin
         regfile_ff[wr_idx] <= regfile_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
      end else if (wr_en) begin
         rf_valid_ff[wr_idx] <= 1'b1;
      end
   end

   // operand read with bypass of the write retiring this cycle
   always_ff @(posedge clock) begin
      if (pop) begin
         ex_uop_ff <= head_uop;
         if (wr_en && (wr_idx == head_uop.dest_idx)) begin
            rd_dest_ff <= regfile_in;
         end else if (rf_valid_ff[head_uop.dest_idx]) begin
            rd_dest_ff <= regfile_ff[head_uop.dest_idx];
         end else begin
            rd_dest_ff <= '0;
         end
         if (wr_en && (wr_idx == head_uop.src_idx)) begin
            rd_src_ff <= regfile_in;
         end else if (rf_valid_ff[head_uop.src_idx]) begin
            rd_src_ff <= regfile_ff[head_uop.src_idx];
         end else begin
            rd_src_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sign_ff      <= 1'b0;
         zero_ff      <= 1'b0;
      end else begin
         if (pop) begin
            ex_valid_ff <= 1'b1;
         end else if (advance) begin
            ex_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            sign_ff      <= sign_in;
            zero_ff      <= zero_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_ff <= rsp_value_in;
         rsp_sign_ff  <= sign_in;
         rsp_zero_ff  <= zero_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.dest_value = rsp_value_ff;
   assign rsp_bus.sign_out   = rsp_sign_ff;
   assign rsp_bus.zero_out   = rsp_zero_ff;

endmodule

/* rtl/cpu16_register_file_alu.sv */
// Executes mov/add/sub/cmp operations on a twelve-entry 16-bit register file.
// One request beat per clock is accepted and one response beat per clock is
// returned when the response side is ready; a request moves through a queue
// slot, the operand registers and the response register. The rate is set by
// the single read-modify-write of the register file in the back end, which
// forwards the retiring write to the next operand read. A two-entry queue
// sits between the decode front end and the back end; req ready drops only
// when it fills. Register file and flags reset to zero with no clearing pass.
`include "cpu16_register_file_alu_macros.svh"

module cpu16_register_file_alu (
   input logic       clock,
   input logic       reset,
   crf_req_if.sink   req_bus,
   crf_rsp_if.source rsp_bus
);

   logic                   q_push;
   logic                   q_pop;
   crf_pkg::crf_uop_type   q_push_uop;
   crf_pkg::crf_uop_type   q_head_uop;
   crf_pkg::crf_qstat_type q_stat;

   crf_front u_front (
      .req_bus  (req_bus),
      .q_stat   (q_stat),
      .push     (q_push),
      .push_uop (q_push_uop)
   );

   crf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_uop (q_push_uop),
      .pop      (q_pop),
      .head_uop (q_head_uop),
      .q_stat   (q_stat)
   );

   crf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_uop (q_head_uop),
      .q_stat   (q_stat),
      .pop      (q_pop),
      .rsp_bus  (rsp_bus)
   );

   `CRF_ASSERT_NXT(a_push_lands, q_push && !q_pop, q_stat.count != '0, "queue lost a beat")
   `CRF_ASSERT_IMP(a_pop_nonempty, q_pop, !q_stat.empty, "pop from empty queue")
   `CRF_ASSERT_IMP(a_count_bound, 1'b1, q_stat.count <= crf_pkg::QUEUE_FULL_CNT, "queue overflow")

endmodule
